@@ sv/power_rail_sequencer_assert.svh @@
// assertion macros for the power rail sequencer checker
// no dependencies; the checker pulls this in by include
`ifndef POWER_RAIL_SEQUENCER_ASSERT_SVH
`define POWER_RAIL_SEQUENCER_ASSERT_SVH

// same-cycle implication, held off while reset is asserted
`define PRS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("power_rail_sequencer: same-cycle check failed");

// next-cycle implication, held off while reset is asserted
`define PRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("power_rail_sequencer: next-cycle check failed");

`endif

@@ sv/prs_pkg.sv @@
// types and constants shared by the power rail sequencer modules
// no dependencies
`timescale 1ns / 1ps

package prs_pkg;

    // sequencing phases, numbered as reported on the phase output
    typedef enum logic [3:0] {
        PH_DELAY      = 4'd0,
        PH_SETTLE     = 4'd1,
        PH_RAIL_1V0   = 4'd2,
        PH_RAIL_1V2   = 4'd3,
        PH_RAIL_3V3   = 4'd4,
        PH_RAIL_2V5   = 4'd5,
        PH_RAIL_1V8   = 4'd6,
        PH_SUB_1V8IO  = 4'd7,
        PH_SUB_VTT    = 4'd8,
        PH_RUN        = 4'd9,
        PH_HALT       = 4'd10
    } phase_t;

    // fault codes
    localparam logic [3:0] FAULT_NONE      = 4'd0;
    localparam logic [3:0] FAULT_TMO_1V0   = 4'd1;
    localparam logic [3:0] FAULT_TMO_1V2   = 4'd2;
    localparam logic [3:0] FAULT_TMO_3V3   = 4'd3;
    localparam logic [3:0] FAULT_TMO_2V5   = 4'd4;
    localparam logic [3:0] FAULT_TMO_1V8   = 4'd5;
    localparam logic [3:0] FAULT_SUB_1V8IO = 4'd6;
    localparam logic [3:0] FAULT_SUB_VTT   = 4'd7;
    localparam logic [3:0] FAULT_LOST_3V3  = 4'd8;
    localparam logic [3:0] FAULT_LOST_2V5  = 4'd9;
    localparam logic [3:0] FAULT_LOST_1V8  = 4'd10;
    localparam logic [3:0] FAULT_LOST_1V2  = 4'd11;
    localparam logic [3:0] FAULT_LOST_1V0  = 4'd12;

    // rail enable bit positions
    localparam int EN_12V0  = 0;
    localparam int EN_1V0   = 1;
    localparam int EN_1V2   = 2;
    localparam int EN_1V8   = 3;
    localparam int EN_1V8IO = 4;
    localparam int EN_VTT   = 5;
    localparam int EN_2V5   = 6;
    localparam int EN_3V3   = 7;

    // power-good bit positions
    localparam int PG_1V0 = 0;
    localparam int PG_1V2 = 1;
    localparam int PG_1V8 = 2;
    localparam int PG_2V5 = 3;
    localparam int PG_3V3 = 4;

    // led and reset bit positions
    localparam int LED_STATUS = 0;
    localparam int LED_FAIL   = 1;
    localparam int LED_PWROK  = 2;
    localparam int LED_ALLOK  = 3;
    localparam int RST_MCU    = 4;
    localparam int RST_FPGA   = 5;

    // configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_DELAY   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAIN_SETTLE   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_RAIL_TIMEOUT  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SUBRAIL_WIN   = 2'd3;

    localparam logic [15:0] START_DELAY_RST = 16'd50000;
    localparam logic [9:0]  MAIN_SETTLE_RST = 10'd50;
    localparam logic [9:0]  RAIL_TMO_RST    = 10'd50;
    localparam logic [9:0]  SUBRAIL_WIN_RST = 10'd100;

    typedef struct packed {
        logic [15:0] start_delay_ticks;
        logic [9:0]  main_settle_ticks;
        logic [9:0]  rail_timeout_ticks;
        logic [9:0]  subrail_window_ticks;
    } prs_cfg_t;

    typedef struct packed {
        logic [4:0] rail_power_good;
        logic       fpga_configured;
    } prs_in_t;

    typedef struct packed {
        logic [7:0] rail_enables;
        logic       status_led;
        logic       shutdown_led;
        logic       power_ok_led;
        logic       system_ok_led;
        logic       mcu_reset_n;
        logic       fpga_reset_n;
        logic [3:0] phase;
        logic [3:0] fault_code;
    } prs_out_t;

    // sequencer state beside the phase
    typedef struct packed {
        logic [15:0] tick_count;
        logic        fpga_up;
        logic [3:0]  fault;
        logic [7:0]  enable;
        logic [5:0]  led_reset;
    } prs_data_t;

endpackage

@@ sv/prs_cfg.sv @@
// configuration registers of the power rail sequencer
// depends on prs_pkg
`timescale 1ns / 1ps

module prs_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [prs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [prs_pkg::CFG_DATA_W-1:0]  cfg_data,
    output prs_pkg::prs_cfg_t               cfg
);
    import prs_pkg::*;

    prs_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_delay_ticks    <= START_DELAY_RST;
            cfg_reg.main_settle_ticks    <= MAIN_SETTLE_RST;
            cfg_reg.rail_timeout_ticks   <= RAIL_TMO_RST;
            cfg_reg.subrail_window_ticks <= SUBRAIL_WIN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_START_DELAY:  cfg_reg.start_delay_ticks    <= cfg_data;
                CFG_MAIN_SETTLE:  cfg_reg.main_settle_ticks    <= cfg_data[9:0];
                CFG_RAIL_TIMEOUT: cfg_reg.rail_timeout_ticks   <= cfg_data[9:0];
                CFG_SUBRAIL_WIN:  cfg_reg.subrail_window_ticks <= cfg_data[9:0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ sv/prs_step.sv @@
// next-state logic for one tick of the power rail sequencer
// depends on prs_pkg
`timescale 1ns / 1ps

module prs_step (
    input  prs_pkg::phase_t    phase_cur,
    input  prs_pkg::prs_data_t data_cur,
    input  prs_pkg::prs_in_t   item,
    input  prs_pkg::prs_cfg_t  cfg,
    output prs_pkg::phase_t    phase_next,
    output prs_pkg::prs_data_t data_next
);
    import prs_pkg::*;

    logic [15:0] limit;
    logic        timer_done;
    logic        advance;
    logic        do_panic;
    logic        counting;
    phase_t      phase_adv;
    logic [7:0]  adv_en;
    logic [5:0]  adv_leds;
    logic [3:0]  panic_code;
    logic [4:0]  pg;
    logic [3:0]  lost_code;

    assign pg = item.rail_power_good;

    always_comb
    begin
        case (phase_cur)
            PH_DELAY:  limit = cfg.start_delay_ticks;
            PH_SETTLE: limit = 16'(cfg.main_settle_ticks);
            PH_RAIL_1V0, PH_RAIL_1V2, PH_RAIL_3V3, PH_RAIL_2V5, PH_RAIL_1V8:
                limit = 16'(cfg.rail_timeout_ticks);
            PH_SUB_1V8IO, PH_SUB_VTT:
                limit = 16'(cfg.subrail_window_ticks);
            default:   limit = 16'd0;
        endcase
    end

    assign timer_done = data_cur.tick_count >= limit;

    // first missing rail in monitor order
    always_comb
    begin
        if (!pg[PG_3V3])
            lost_code = FAULT_LOST_3V3;
        else if (!pg[PG_2V5])
            lost_code = FAULT_LOST_2V5;
        else if (!pg[PG_1V8])
            lost_code = FAULT_LOST_1V8;
        else if (!pg[PG_1V2])
            lost_code = FAULT_LOST_1V2;
        else
            lost_code = FAULT_LOST_1V0;
    end

    // per-phase decisions shared by the two blocks below
    always_comb
    begin
        advance    = 1'b0;
        do_panic   = 1'b0;
        counting   = 1'b0;
        phase_adv  = phase_cur;
        adv_en     = '0;
        adv_leds   = '0;
        panic_code = FAULT_NONE;
        case (phase_cur)
            PH_DELAY:
            begin
                advance              = timer_done;
                counting             = !timer_done;
                phase_adv            = PH_SETTLE;
                adv_en[EN_12V0]      = 1'b1;
                adv_leds[LED_STATUS] = 1'b1;
            end
            PH_SETTLE:
            begin
                advance         = timer_done;
                counting        = !timer_done;
                phase_adv       = PH_RAIL_1V0;
                adv_en[EN_1V0]  = 1'b1;
            end
            PH_RAIL_1V0:
            begin
                advance        = pg[PG_1V0];
                do_panic       = !pg[PG_1V0] && timer_done;
                counting       = !pg[PG_1V0] && !timer_done;
                phase_adv      = PH_RAIL_1V2;
                adv_en[EN_1V2] = 1'b1;
                panic_code     = FAULT_TMO_1V0;
            end
            PH_RAIL_1V2:
            begin
                advance        = pg[PG_1V2];
                do_panic       = !pg[PG_1V2] && timer_done;
                counting       = !pg[PG_1V2] && !timer_done;
                phase_adv      = PH_RAIL_3V3;
                adv_en[EN_3V3] = 1'b1;
                panic_code     = FAULT_TMO_1V2;
            end
            PH_RAIL_3V3:
            begin
                advance        = pg[PG_3V3];
                do_panic       = !pg[PG_3V3] && timer_done;
                counting       = !pg[PG_3V3] && !timer_done;
                phase_adv      = PH_RAIL_2V5;
                adv_en[EN_2V5] = 1'b1;
                panic_code     = FAULT_TMO_3V3;
            end
            PH_RAIL_2V5:
            begin
                advance        = pg[PG_2V5];
                do_panic       = !pg[PG_2V5] && timer_done;
                counting       = !pg[PG_2V5] && !timer_done;
                phase_adv      = PH_RAIL_1V8;
                adv_en[EN_1V8] = 1'b1;
                panic_code     = FAULT_TMO_2V5;
            end
            PH_RAIL_1V8:
            begin
                advance          = pg[PG_1V8];
                do_panic         = !pg[PG_1V8] && timer_done;
                counting         = !pg[PG_1V8] && !timer_done;
                phase_adv        = PH_SUB_1V8IO;
                adv_en[EN_1V8IO] = 1'b1;
                panic_code       = FAULT_TMO_1V8;
            end
            PH_SUB_1V8IO:
            begin
                // window end wins over a low 1V8 on the same tick
                advance        = timer_done;
                do_panic       = !timer_done && !pg[PG_1V8];
                counting       = !timer_done && pg[PG_1V8];
                phase_adv      = PH_SUB_VTT;
                adv_en[EN_VTT] = 1'b1;
                panic_code     = FAULT_SUB_1V8IO;
            end
            PH_SUB_VTT:
            begin
                advance             = timer_done;
                do_panic            = !timer_done && !pg[PG_1V8];
                counting            = !timer_done && pg[PG_1V8];
                phase_adv           = PH_RUN;
                adv_leds[LED_PWROK] = 1'b1;
                adv_leds[RST_MCU]   = 1'b1;
                adv_leds[RST_FPGA]  = 1'b1;
                panic_code          = FAULT_SUB_VTT;
            end
            PH_RUN:
            begin
                do_panic   = pg != '1;
                panic_code = lost_code;
            end
            default:
            begin
                advance = 1'b0;
            end
        endcase
    end

    // next phase
    always_comb
    begin
        if (do_panic)
            phase_next = PH_HALT;
        else if (advance)
            phase_next = phase_adv;
        else
            phase_next = phase_cur;
    end

    // counter, enables, leds and fault code
    always_comb
    begin
        data_next = data_cur;
        if (phase_cur == PH_RUN)
        begin
            data_next.fpga_up              = item.fpga_configured;
            data_next.led_reset[LED_ALLOK] = item.fpga_configured;
        end
        if (do_panic)
        begin
            data_next.enable               = '0;
            data_next.led_reset[LED_FAIL]  = 1'b1;
            data_next.led_reset[LED_PWROK] = 1'b0;
            data_next.led_reset[LED_ALLOK] = 1'b0;
            data_next.fault                = panic_code;
        end
        else if (advance)
        begin
            data_next.tick_count = '0;
            data_next.enable     = data_cur.enable | adv_en;
            data_next.led_reset  = data_cur.led_reset | adv_leds;
        end
        else if (counting)
        begin
            data_next.tick_count = data_cur.tick_count + 16'd1;
        end
    end

endmodule

@@ sv/power_rail_sequencer.sv @@
// power rail sequencer top level: config registers, tick logic, state and result register
// depends on prs_pkg, prs_cfg, prs_step
// the state register doubles as the result register; a result appears in the cycle
// after its tick transaction is accepted; one tick per cycle while no result is stalled
// the only loop is phase/counter state through prs_step and the state register
// reset: all rails off, phase delay, registers at their documented defaults
`timescale 1ns / 1ps

module power_rail_sequencer (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_stall,
    input  prs_pkg::prs_in_t                item,
    output logic                            result_valid,
    input  logic                            result_stall,
    output prs_pkg::prs_out_t               result,
    input  logic                            cfg_we,
    input  logic [prs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [prs_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import prs_pkg::*;

    prs_cfg_t  cfg;
    phase_t    phase_reg;
    phase_t    phase_next;
    prs_data_t data_reg;
    prs_data_t data_next;
    logic      result_valid_reg;
    logic      item_accept;
    logic      result_accept;

    prs_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    prs_step u_step (
        .phase_cur  (phase_reg),
        .data_cur   (data_reg),
        .item       (item),
        .cfg        (cfg),
        .phase_next (phase_next),
        .data_next  (data_next)
    );

    // a waiting result only blocks when downstream holds it
    assign item_stall    = result_valid_reg && result_stall;
    assign item_accept   = item_valid && !item_stall;
    assign result_accept = result_valid_reg && !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_DELAY;
            data_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_accept)
            begin
                phase_reg <= phase_next;
                data_reg  <= data_next;
            end
            if (item_accept)
                result_valid_reg <= 1'b1;
            else if (result_accept)
                result_valid_reg <= 1'b0;
        end
    end

    assign result_valid         = result_valid_reg;
    assign result.rail_enables  = data_reg.enable;
    assign result.status_led    = data_reg.led_reset[LED_STATUS];
    assign result.shutdown_led  = data_reg.led_reset[LED_FAIL];
    assign result.power_ok_led  = data_reg.led_reset[LED_PWROK];
    assign result.system_ok_led = data_reg.led_reset[LED_ALLOK];
    assign result.mcu_reset_n   = data_reg.led_reset[RST_MCU];
    assign result.fpga_reset_n  = data_reg.led_reset[RST_FPGA];
    assign result.phase         = phase_reg;
    assign result.fault_code    = data_reg.fault;

endmodule

@@ sv/prs_checker.sv @@
// port-level checks for the power rail sequencer, bound to the top level
// depends on prs_pkg and power_rail_sequencer_assert.svh
`timescale 1ns / 1ps
`include "power_rail_sequencer_assert.svh"

module prs_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              item_valid,
    input logic              item_stall,
    input logic              result_valid,
    input logic              result_stall,
    input prs_pkg::prs_out_t result
);
    import prs_pkg::*;

    logic tick_accept;
    logic result_held;
    logic shut_shown;
    logic fault_shown;
    logic halt_shown;

    assign tick_accept = item_valid && !item_stall;
    assign result_held = result_valid && result_stall;
    assign shut_shown  = result_valid && result.shutdown_led;
    assign fault_shown = result_valid && result.fault_code != FAULT_NONE;
    assign halt_shown  = result.phase == PH_HALT && result.shutdown_led;

    // every accepted tick transaction yields a result next cycle
    `PRS_ASSERT_NEXT(a_accept_gives_result, clk, rst_n, tick_accept, result_valid)

    // a held result keeps its payload
    `PRS_ASSERT_NEXT(a_result_held, clk, rst_n, result_held, result_valid && $stable(result))

    // after a shutdown no rail stays enabled
    `PRS_ASSERT_IMPL(a_fail_rails_off, clk, rst_n, shut_shown, result.rail_enables == 8'd0)

    // a fault code is only reported once halted, and halting always lights the shutdown led
    `PRS_ASSERT_IMPL(a_fault_halts, clk, rst_n, fault_shown, halt_shown)

endmodule

bind power_rail_sequencer prs_checker u_prs_checker (.*);

@@ verif/power_rail_sequencer_test.sv @@
// testbench for power_rail_sequencer: steps one board power-up through every phase,
// holds it running, then drops a rail; results are checked against an in-bench predictor
// depends on prs_pkg and power_rail_sequencer
`timescale 1ns / 1ps

module power_rail_sequencer_test;

    import prs_pkg::*;

    localparam int RUN_CHUNK      = 230;
    localparam int WATCHDOG_LIMIT = 2000;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   item_valid = 1'b0;
    logic                   item_stall;
    prs_in_t                item = '0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    prs_out_t               result;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    power_rail_sequencer u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predicted sequencer state and register copies
    phase_t      seq_phase = PH_DELAY;
    logic [15:0] seq_ticks = '0;
    logic [3:0]  seq_fault = FAULT_NONE;
    logic [7:0]  seq_rails = '0;
    logic [5:0]  seq_lamps = '0;
    logic [15:0] delay_limit  = START_DELAY_RST;
    logic [9:0]  settle_limit = MAIN_SETTLE_RST;
    logic [9:0]  rail_limit   = RAIL_TMO_RST;
    logic [9:0]  window_limit = SUBRAIL_WIN_RST;

    prs_in_t  pending_ticks[$];
    prs_out_t expected_status[$];

    int send_gap_pct = 0;
    int stall_pct    = 0;
    int fail_count   = 0;
    int ticks_sent   = 0;
    int status_checked = 0;
    int quiet_cycles = 0;

    // regulated rails in start order
    function automatic int start_en_pos(int k);
        case (k)
            0: return EN_1V0;
            1: return EN_1V2;
            2: return EN_3V3;
            3: return EN_2V5;
            default: return EN_1V8;
        endcase
    endfunction

    function automatic int start_pg_pos(int k);
        case (k)
            0: return PG_1V0;
            1: return PG_1V2;
            2: return PG_3V3;
            3: return PG_2V5;
            default: return PG_1V8;
        endcase
    endfunction

    // order in which a running board is checked
    function automatic int watch_pg_pos(int i);
        case (i)
            0: return PG_3V3;
            1: return PG_2V5;
            2: return PG_1V8;
            3: return PG_1V2;
            default: return PG_1V0;
        endcase
    endfunction

    task automatic enter_phase(phase_t next, logic [7:0] en_mask);
        seq_phase = next;
        seq_ticks = '0;
        seq_rails = seq_rails | en_mask;
    endtask

    task automatic shut_down(logic [3:0] code);
        seq_rails = '0;
        seq_lamps[LED_FAIL]  = 1'b1;
        seq_lamps[LED_PWROK] = 1'b0;
        seq_lamps[LED_ALLOK] = 1'b0;
        seq_fault = code;
        seq_phase = PH_HALT;
    endtask

    task automatic advance_sequencer(input prs_in_t t, output prs_out_t status);
        int  k;
        int  i;
        bit  tripped;
        tripped = 1'b0;
        k = int'(seq_phase) - int'(PH_RAIL_1V0);
        case (seq_phase)
            PH_DELAY:
                if (seq_ticks >= delay_limit)
                begin
                    seq_lamps[LED_STATUS] = 1'b1;
                    enter_phase(PH_SETTLE, 8'b1 << EN_12V0);
                end
                else
                    seq_ticks++;
            PH_SETTLE:
                if (seq_ticks >= 16'(settle_limit))
                    enter_phase(PH_RAIL_1V0, 8'b1 << EN_1V0);
                else
                    seq_ticks++;
            PH_RAIL_1V0, PH_RAIL_1V2, PH_RAIL_3V3, PH_RAIL_2V5, PH_RAIL_1V8:
                if (t.rail_power_good[start_pg_pos(k)])
                begin
                    if (k < 4)
                        enter_phase(phase_t'(seq_phase + 4'd1), 8'b1 << start_en_pos(k + 1));
                    else
                        enter_phase(PH_SUB_1V8IO, 8'b1 << EN_1V8IO);
                end
                else if (seq_ticks >= 16'(rail_limit))
                    shut_down(4'(FAULT_TMO_1V0 + k));
                else
                    seq_ticks++;
            PH_SUB_1V8IO, PH_SUB_VTT:
                // window over: move on without looking at 1V8
                if (seq_ticks >= 16'(window_limit))
                begin
                    if (seq_phase == PH_SUB_1V8IO)
                        enter_phase(PH_SUB_VTT, 8'b1 << EN_VTT);
                    else
                    begin
                        enter_phase(PH_RUN, 8'h00);
                        seq_lamps[LED_PWROK] = 1'b1;
                        seq_lamps[RST_MCU]   = 1'b1;
                        seq_lamps[RST_FPGA]  = 1'b1;
                    end
                end
                else if (!t.rail_power_good[PG_1V8])
                    shut_down(seq_phase == PH_SUB_1V8IO ? FAULT_SUB_1V8IO : FAULT_SUB_VTT);
                else
                    seq_ticks++;
            PH_RUN:
            begin
                seq_lamps[LED_ALLOK] = t.fpga_configured;
                for (i = 0; i < 5; i++)
                begin
                    if (!tripped && !t.rail_power_good[watch_pg_pos(i)])
                    begin
                        shut_down(4'(FAULT_LOST_3V3 + i));
                        tripped = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        status.rail_enables  = seq_rails;
        status.status_led    = seq_lamps[LED_STATUS];
        status.shutdown_led  = seq_lamps[LED_FAIL];
        status.power_ok_led  = seq_lamps[LED_PWROK];
        status.system_ok_led = seq_lamps[LED_ALLOK];
        status.mcu_reset_n   = seq_lamps[RST_MCU];
        status.fpga_reset_n  = seq_lamps[RST_FPGA];
        status.phase         = seq_phase;
        status.fault_code    = seq_fault;
    endtask

    task automatic compare_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!item_valid || !item_stall)
            begin
                if (pending_ticks.size() != 0 && $urandom_range(99) >= send_gap_pct)
                begin
                    item       <= pending_ticks.pop_front();
                    item_valid <= 1'b1;
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
            result_stall <= ($urandom_range(99) < stall_pct);
    end

    // monitor: check results, then track register writes and accepted ticks
    always @(posedge clk)
    begin : scoreboard
        prs_out_t want;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_status.size() == 0)
                begin
                    $error("result transaction with no tick pending");
                    fail_count++;
                end
                else
                begin
                    want = expected_status.pop_front();
                    compare_field("rail_enables", want.rail_enables, result.rail_enables);
                    compare_field("status_led", want.status_led, result.status_led);
                    compare_field("shutdown_led", want.shutdown_led, result.shutdown_led);
                    compare_field("power_ok_led", want.power_ok_led, result.power_ok_led);
                    compare_field("system_ok_led", want.system_ok_led, result.system_ok_led);
                    compare_field("mcu_reset_n", want.mcu_reset_n, result.mcu_reset_n);
                    compare_field("fpga_reset_n", want.fpga_reset_n, result.fpga_reset_n);
                    compare_field("phase", want.phase, result.phase);
                    compare_field("fault_code", want.fault_code, result.fault_code);
                    status_checked++;
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_START_DELAY:  delay_limit  = cfg_data;
                    CFG_MAIN_SETTLE:  settle_limit = cfg_data[9:0];
                    CFG_RAIL_TIMEOUT: rail_limit   = cfg_data[9:0];
                    CFG_SUBRAIL_WIN:  window_limit = cfg_data[9:0];
                    default: ;
                endcase
            end
            if (item_valid && !item_stall)
            begin
                advance_sequencer(item, want);
                expected_status.push_back(want);
                ticks_sent++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", quiet_cycles);
                $display("Regression FAIL");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_tick(logic [4:0] pg, logic done);
        prs_in_t t;
        t.rail_power_good = pg;
        t.fpga_configured = done;
        pending_ticks.push_back(t);
    endtask

    task automatic push_random_tick();
        push_tick(5'($urandom), 1'($urandom));
    endtask

    // random power-good pattern with one bit forced
    task automatic push_pg_tick(int pos, logic level);
        logic [4:0] pg;
        pg = 5'($urandom);
        pg[pos] = level;
        push_tick(pg, 1'($urandom));
    endtask

    task automatic wait_drained();
        while (pending_ticks.size() != 0 || item_valid || expected_status.size() != 0)
            @(posedge clk);
    endtask

    // 10-bit registers get fixed or random junk in the unused upper bits from the callers
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [15:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_idling(int mode);
        case (mode)
            0:
            begin
                send_gap_pct = 18;
                stall_pct    = 51;
            end
            1:
            begin
                send_gap_pct = 51;
                stall_pct    = 18;
            end
            default:
            begin
                send_gap_pct = 0;
                stall_pct    = 0;
            end
        endcase
    endtask

    initial
    begin
        int rail_wait;
        int k;
        int chunk;
        int win;

        set_idling(0);
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // start delay at its reset value, power-good ignored
        repeat (3) push_random_tick();
        push_tick(5'h00, 1'b0);
        push_tick(5'h1F, 1'b1);
        wait_drained();

        write_reg(CFG_START_DELAY, 16'hFFFF);
        write_reg(CFG_RAIL_TIMEOUT, {6'h3F, 10'h3FF});
        write_reg(CFG_SUBRAIL_WIN, {6'h2A, 10'h3FF});
        repeat (5) push_random_tick();
        wait_drained();

        // zero delay ends phase 0 on the next tick, long settle keeps counting
        write_reg(CFG_START_DELAY, 16'h0000);
        write_reg(CFG_MAIN_SETTLE, {6'h15, 10'h3FF});
        repeat (6) push_random_tick();
        wait_drained();

        // zero settle, and a zero timeout allows exactly one sample of 1V0
        write_reg(CFG_MAIN_SETTLE, {6'h2A, 10'h000});
        write_reg(CFG_RAIL_TIMEOUT, {6'($urandom), 10'h000});
        push_random_tick();
        push_pg_tick(PG_1V0, 1'b1);
        wait_drained();

        // remaining rails come up late, one of them on its very last sample
        win = $urandom_range(2, 6);
        write_reg(CFG_RAIL_TIMEOUT, {6'($urandom), 10'(win)});
        for (k = 1; k < 5; k++)
        begin
            rail_wait = (k == 2) ? win : $urandom_range(0, win);
            repeat (rail_wait) push_pg_tick(start_pg_pos(k), 1'b0);
            push_pg_tick(start_pg_pos(k), 1'b1);
        end
        wait_drained();

        // 1V8IO window watched with 1V8 good, closing tick is not tested
        win = $urandom_range(1, 6);
        write_reg(CFG_SUBRAIL_WIN, {6'($urandom), 10'(win)});
        repeat (win) push_pg_tick(PG_1V8, 1'b1);
        push_random_tick();
        wait_drained();

        // zero window: VTT passes even with 1V8 low
        write_reg(CFG_SUBRAIL_WIN, {6'($urandom), 10'h000});
        push_pg_tick(PG_1V8, 1'b0);
        wait_drained();

        // running: all rails good, FPGA done toggling, registers rewritten in between
        for (chunk = 0; chunk < 3; chunk++)
        begin
            set_idling(chunk);
            repeat (RUN_CHUNK) push_tick(5'h1F, 1'($urandom));
            wait_drained();
            write_reg(CFG_START_DELAY, 16'($urandom));
            write_reg(CFG_MAIN_SETTLE, 16'($urandom));
            write_reg(CFG_RAIL_TIMEOUT, 16'($urandom));
            write_reg(CFG_SUBRAIL_WIN, 16'($urandom));
        end

        // lose at least one rail, then the halted block must hold
        set_idling(2);
        push_tick(5'($urandom_range(0, 30)), 1'($urandom));
        repeat (8) push_random_tick();
        wait_drained();
        repeat (4) @(posedge clk);

        $display("%0d ticks checked from power-up through all rails and sub-rails, run and shutdown",
                 status_checked);
        $display("ended in phase %0d with fault code %0d", seq_phase, seq_fault);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
